>>> design/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, sampled on clk, quiet during reset
`define SXF_ASSERT_IMPL(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, sampled on clk, quiet during reset
`define SXF_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> design/sxf_pkg.sv
`default_nettype none

package sxf_pkg;

	localparam int ROW_W       = 64;
	localparam int MAX_ADDR_W  = 6;
	localparam int OP_W        = 2;
	localparam int S_TDATA_W   = 32;
	localparam int M_TDATA_W   = 72;
	localparam int QUEUE_DEPTH = 2;

	// operation codes on s_tuser
	localparam logic [OP_W-1:0] OP_CLEAR  = 2'd0;
	localparam logic [OP_W-1:0] OP_DRAW   = 2'd1;
	localparam logic [OP_W-1:0] OP_READ   = 2'd2;
	localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

	// result kinds on m_tuser
	localparam logic KIND_DRAW = 1'b0;
	localparam logic KIND_READ = 1'b1;

	typedef struct packed {
		logic [OP_W-1:0]       op;
		logic [MAX_ADDR_W-1:0] addr;
		logic [ROW_W-1:0]      mask;
		logic                  last;
	} sxf_cmd_t;

	typedef struct packed {
		logic full;
		logic empty;
	} sxf_qstat_t;

endpackage

`default_nettype wire

>>> design/sxf_front.sv
`default_nettype none

module sxf_front import sxf_pkg::*; #(
	parameter int DISPLAY_WIDTH  = 64,
	parameter int DISPLAY_HEIGHT = 32
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 s_tvalid,
	output logic                      s_tready,
	input  wire logic [S_TDATA_W-1:0] s_tdata,
	input  wire logic                 s_tlast,
	input  wire logic [OP_W-1:0]      s_tuser,
	input  wire sxf_qstat_t           qstat,
	output logic                      push,
	output sxf_cmd_t                  cmd
);

	localparam logic [6:0] WIDTH_M  = 7'(DISPLAY_WIDTH);
	localparam logic [6:0] HEIGHT_M = 7'(DISPLAY_HEIGHT);

	logic       accept;
	logic [7:0] x0;
	logic [7:0] y0;
	logic [7:0] sb;
	logic [4:0] sel;
	logic [4:0] cnt_q;
	logic [8:0] xm;
	logic [8:0] ysum;
	logic [8:0] yaddr;
	logic [8:0] raddr;
	logic [6:0] col;
	logic [ROW_W-1:0] mask;

	// remainder by conditional subtraction of m shifted, six narrow steps
	function automatic logic [8:0] reduce(input logic [8:0] v, input logic [6:0] m);
		logic [14:0] r;
		logic [14:0] d;
		r = {6'd0, v};
		for (int k = 5; k >= 0; k--) begin
			d = {8'd0, m} << k;
			if (r >= d)
				r = r - d;
		end
		return r[8:0];
	endfunction

	assign x0  = s_tdata[7:0];
	assign y0  = s_tdata[15:8];
	assign sb  = s_tdata[23:16];
	assign sel = s_tdata[28:24];

	assign s_tready = !qstat.full;
	assign accept   = s_tvalid && s_tready;

	assign xm    = reduce({1'b0, x0}, WIDTH_M);
	assign ysum  = {1'b0, y0} + {4'd0, cnt_q};
	assign yaddr = reduce(ysum, HEIGHT_M);
	assign raddr = reduce({4'd0, sel}, HEIGHT_M);

	// columns of the eight sprite pixels are distinct, so a plain or builds the mask
	always_comb begin
		mask = '0;
		col  = '0;
		for (int c = 0; c < 8; c++) begin
			col = xm[6:0] + 7'(c);
			if (col >= WIDTH_M)
				col = col - WIDTH_M;
			if (sb[3'(7 - c)])
				mask[col[5:0]] = 1'b1;
		end
	end

	assign push = accept && (s_tuser != OP_UNUSED);

	always_comb begin
		cmd.op   = s_tuser;
		cmd.addr = (s_tuser == OP_READ) ? raddr[MAX_ADDR_W-1:0] : yaddr[MAX_ADDR_W-1:0];
		cmd.mask = mask;
		cmd.last = s_tlast;
	end

	// sprite row counter follows accepted draws
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (accept && (s_tuser == OP_DRAW)) begin
			if (s_tlast)
				cnt_q <= '0;
			else
				cnt_q <= cnt_q + 5'd1;
		end
	end

endmodule

`default_nettype wire

>>> design/sxf_queue.sv
`default_nettype none

module sxf_queue import sxf_pkg::*; (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     push,
	input  wire sxf_cmd_t push_cmd,
	input  wire logic     pop,
	output sxf_cmd_t      pop_cmd,
	output sxf_qstat_t    qstat
);

	localparam int PTR_W = $clog2(QUEUE_DEPTH);
	localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(QUEUE_DEPTH - 1);
	localparam logic [PTR_W:0]   FULL_CNT = (PTR_W + 1)'(QUEUE_DEPTH);

	sxf_cmd_t         ent_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [PTR_W:0]   count_q;

	assign qstat.full  = (count_q == FULL_CNT);
	assign qstat.empty = (count_q == '0);
	assign pop_cmd     = ent_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push)
			ent_q[wr_ptr_q] <= push_cmd;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + 1'b1;
			if (pop)
				rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + 1'b1;
			if (push && !pop)
				count_q <= count_q + 1'b1;
			else if (pop && !push)
				count_q <= count_q - 1'b1;
		end
	end

endmodule

`default_nettype wire

>>> design/sxf_back.sv
`default_nettype none

module sxf_back import sxf_pkg::*; #(
	parameter int DISPLAY_HEIGHT = 32
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire sxf_qstat_t  qstat,
	output logic             pop,
	input  wire sxf_cmd_t    cmd,
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [M_TDATA_W-1:0] m_tdata,
	output logic [0:0]       m_tuser
);

	localparam int ADDR_W = $clog2(DISPLAY_HEIGHT);
	localparam int PAD_W  = M_TDATA_W - ROW_W - 1;

	logic [ROW_W-1:0]          mem [DISPLAY_HEIGHT];
	logic [DISPLAY_HEIGHT-1:0] valid_q;
	logic                      collision_q;

	logic                  busy_s1;
	logic [OP_W-1:0]       op_s1;
	logic [ADDR_W-1:0]     addr_s1;
	logic [ROW_W-1:0]      mask_s1;
	logic                  last_s1;
	logic [ROW_W-1:0]      rdata_s1;
	logic                  vld_s1;

	logic                  m_tvalid_q;
	logic [M_TDATA_W-1:0]  m_tdata_q;
	logic                  m_tuser_q;

	logic                  out_free;
	logic [ADDR_W-1:0]     addr;
	logic [ROW_W-1:0]      cur_row;
	logic [ROW_W-1:0]      new_row;
	logic                  hit;
	logic                  is_draw_s1;
	logic                  is_read_s1;
	logic                  emit;
	logic                  res_coll;
	logic [ROW_W-1:0]      res_pix;

	assign out_free = !m_tvalid_q || m_tready;
	// one item in the row memory at a time, and only with room for its result
	assign pop  = !qstat.empty && !busy_s1 && out_free;
	assign addr = cmd.addr[ADDR_W-1:0];

	assign is_draw_s1 = busy_s1 && (op_s1 == OP_DRAW);
	assign is_read_s1 = busy_s1 && (op_s1 == OP_READ);

	assign cur_row = vld_s1 ? rdata_s1 : '0;
	assign hit     = |(cur_row & mask_s1);
	assign new_row = cur_row ^ mask_s1;
	assign emit    = (is_draw_s1 && last_s1) || is_read_s1;

	assign res_coll = is_draw_s1 && (collision_q || hit);
	assign res_pix  = is_read_s1 ? cur_row : '0;

	// row memory: read on issue, write back in the cycle after
	always_ff @(posedge clk) begin
		if (pop)
			rdata_s1 <= mem[addr];
		if (is_draw_s1)
			mem[addr_s1] <= new_row;
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			op_s1   <= cmd.op;
			addr_s1 <= addr;
			mask_s1 <= cmd.mask;
			last_s1 <= cmd.last;
			vld_s1  <= valid_q[addr];
		end
		if (emit) begin
			m_tuser_q <= is_read_s1 ? KIND_READ : KIND_DRAW;
			m_tdata_q <= {PAD_W'(0), res_pix, res_coll};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_s1     <= 1'b0;
			valid_q     <= '0;
			collision_q <= 1'b0;
			m_tvalid_q  <= 1'b0;
		end else begin
			busy_s1 <= pop && (cmd.op != OP_CLEAR);
			if (pop && (cmd.op == OP_CLEAR))
				valid_q <= '0;
			else if (is_draw_s1)
				valid_q[addr_s1] <= 1'b1;
			if (is_draw_s1)
				collision_q <= last_s1 ? 1'b0 : (collision_q || hit);
			if (emit)
				m_tvalid_q <= 1'b1;
			else if (m_tready)
				m_tvalid_q <= 1'b0;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;

endmodule

`default_nettype wire

>>> design/sprite_xor_framebuffer_unit.sv
// Monochrome sprite framebuffer with xor drawing and collision reporting. Each input beat
// carries an operation on s_tuser: clear blanks the whole screen, draw xors one 8-pixel
// sprite row (bit 7 leftmost) onto display row (y_coord + sprite row count) at column
// x_coord, both wrapping around the display, and read returns one 64-bit display row
// (bit 0 is column 0). s_tlast marks the last row of a sprite; that beat produces one
// result beat with the collision flag (set if any lit pixel was turned off during the
// sprite) and restarts the row count. Reads produce one result beat; clears, non-final
// draw rows and the unused operation code produce none. A front end classifies beats and
// works out the row address and pixel mask, a two-entry command queue decouples it from a
// back end that owns the row memory. There a draw or read first reads the row memory, then
// xors and writes back or loads the result; a clear is done at issue. The single-port
// read-modify-write holds off the next command until a draw or read is through. Clear works
// through per-row valid bits, so there is no clearing sweep after reset or on a clear.
`default_nettype none

`include "assert_macros.svh"

module sprite_xor_framebuffer_unit import sxf_pkg::*; #(
	parameter int DISPLAY_WIDTH  = 64,
	parameter int DISPLAY_HEIGHT = 32
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	// command beats
	input  wire logic                 s_tvalid,
	output logic                      s_tready,
	input  wire logic [S_TDATA_W-1:0] s_tdata,  // x_coord, y_coord, sprite_byte, row_select
	input  wire logic                 s_tlast,  // last_row
	input  wire logic [OP_W-1:0]      s_tuser,  // operation
	// result beats
	output logic                      m_tvalid,
	input  wire logic                 m_tready,
	output logic [M_TDATA_W-1:0]      m_tdata,  // collision, row_pixels
	output logic [0:0]                m_tuser   // result_kind
);

	// front to queue
	logic       q_push;
	sxf_cmd_t   q_push_cmd;
	// queue to back
	logic       q_pop;
	sxf_cmd_t   q_cmd;
	sxf_qstat_t q_stat;

	// classify beats, track the sprite row, build row address and pixel mask
	sxf_front #(
		.DISPLAY_WIDTH (DISPLAY_WIDTH),
		.DISPLAY_HEIGHT(DISPLAY_HEIGHT)
	) u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.s_tlast (s_tlast),
		.s_tuser (s_tuser),
		.qstat   (q_stat),
		.push    (q_push),
		.cmd     (q_push_cmd)
	);

	// short command queue so either side can stall alone
	sxf_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (q_push),
		.push_cmd(q_push_cmd),
		.pop     (q_pop),
		.pop_cmd (q_cmd),
		.qstat   (q_stat)
	);

	// row memory, read-modify-write, collision flag and result register
	sxf_back #(
		.DISPLAY_HEIGHT(DISPLAY_HEIGHT)
	) u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.qstat   (q_stat),
		.pop     (q_pop),
		.cmd     (q_cmd),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata),
		.m_tuser (m_tuser)
	);

	`SXF_ASSERT_IMPL(a_no_overflow, q_push, !q_stat.full, "command queue overflow")
	`SXF_ASSERT_IMPL(a_no_underflow, q_pop, !q_stat.empty, "command queue underflow")
	`SXF_ASSERT_NEXT(a_rmw_spacing, q_pop && (q_cmd.op != OP_CLEAR), !q_pop, "row access overlap")
	`SXF_ASSERT_IMPL(a_read_no_coll, m_tvalid && (m_tuser == KIND_READ), !m_tdata[0], "read with collision")
	`SXF_ASSERT_IMPL(a_draw_no_pix, m_tvalid && (m_tuser == KIND_DRAW), m_tdata[ROW_W:1] == '0, "draw with pixels")

endmodule

`default_nettype wire
